/* design/npcm_pkg.sv */
// shared types and constants for the nearest palette color match block
package npcm_pkg;

    localparam int PALETTE_DEPTH = 64;
    localparam int IDX_W         = 6;
    localparam int CHAN_W        = 8;
    localparam int ERR_W         = 18;
    localparam int TOTAL_W       = 40;
    localparam int S_DATA_W      = 32;
    localparam int M_DATA_W      = 88;

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_PIXEL = 1'b1
    } req_t;

    typedef struct packed
    {
        req_t              req_type;
        logic [IDX_W-1:0]  entry_index;
        logic              entry_is_unit;
        logic [CHAN_W-1:0] color_r;
        logic [CHAN_W-1:0] color_g;
        logic [CHAN_W-1:0] color_b;
        logic              first_pixel;
    } item_t;

    typedef struct packed
    {
        logic              have;
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [ERR_W-1:0]  err;
    } best_t;

    typedef struct packed
    {
        logic  valid;
        item_t item;
        best_t best;
    } stage_t;

    function automatic logic [2*CHAN_W-1:0] chan_sq(input logic [CHAN_W-1:0] x,
                                                    input logic [CHAN_W-1:0] y);
        logic [CHAN_W-1:0] d;
        d = (x > y) ? (x - y) : (y - x);
        return d * d;
    endfunction

endpackage

/* design/npcm_cell.sv */
// one palette cell: holds an entry, takes loads aimed at it and scores passing pixels
module npcm_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [npcm_pkg::IDX_W-1:0] cell_id,
    input  npcm_pkg::stage_t           stage_in,
    output npcm_pkg::stage_t           stage_out
);

    logic [3*npcm_pkg::CHAN_W-1:0] color_reg;
    logic                          usable_reg;
    npcm_pkg::stage_t              a_reg;
    logic [npcm_pkg::ERR_W-1:0]    a_err_reg;
    logic [npcm_pkg::ERR_W-1:0]    a_err_next;
    logic                          a_use_reg;
    logic                          a_use_next;
    npcm_pkg::stage_t              b_reg;
    npcm_pkg::stage_t              b_next;
    logic                          load_hit;

    assign load_hit = stage_in.valid && (stage_in.item.req_type == npcm_pkg::REQ_LOAD)
                      && (stage_in.item.entry_index == cell_id);

    always_comb
    begin
        a_err_next = npcm_pkg::ERR_W'(npcm_pkg::chan_sq(color_reg[23:16], stage_in.item.color_r))
                   + npcm_pkg::ERR_W'(npcm_pkg::chan_sq(color_reg[15:8],  stage_in.item.color_g))
                   + npcm_pkg::ERR_W'(npcm_pkg::chan_sq(color_reg[7:0],   stage_in.item.color_b));
        a_use_next = usable_reg && (stage_in.item.req_type == npcm_pkg::REQ_PIXEL);
    end

    // palette entry, written as a load transaction passes this cell
    always_ff @(posedge clk)
    begin
        if (advance && load_hit)
        begin
            color_reg <= {stage_in.item.color_r, stage_in.item.color_g, stage_in.item.color_b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg <= 1'b0;
        end
        else if (advance && load_hit)
        begin
            usable_reg <= stage_in.item.entry_is_unit;
        end
    end

    // strict compare keeps the lowest index on a tie
    always_comb
    begin
        b_next = a_reg;
        if (a_reg.valid && a_use_reg && (!a_reg.best.have || (a_err_reg < a_reg.best.err)))
        begin
            b_next.best.have = 1'b1;
            b_next.best.idx  = cell_id;
            b_next.best.r    = color_reg[23:16];
            b_next.best.g    = color_reg[15:8];
            b_next.best.b    = color_reg[7:0];
            b_next.best.err  = a_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            a_err_reg <= '0;
            a_use_reg <= 1'b0;
            b_reg     <= '0;
        end
        else if (advance)
        begin
            a_reg     <= stage_in;
            a_err_reg <= a_err_next;
            a_use_reg <= a_use_next;
            b_reg     <= b_next;
        end
    end

    assign stage_out = b_reg;

endmodule

/* design/npcm_out.sv */
// output register with the saturating running error total
module npcm_out
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  npcm_pkg::stage_t                  stage_in,
    output logic                              out_valid,
    output npcm_pkg::best_t                   out_best,
    output logic [npcm_pkg::TOTAL_W-1:0]      out_total
);

    logic                             valid_reg;
    logic                             valid_next;
    npcm_pkg::best_t                  best_reg;
    logic [npcm_pkg::TOTAL_W-1:0]     total_reg;
    logic [npcm_pkg::TOTAL_W-1:0]     total_next;
    logic [npcm_pkg::TOTAL_W-1:0]     base;
    logic [npcm_pkg::TOTAL_W:0]       sum;

    always_comb
    begin
        valid_next = stage_in.valid && (stage_in.item.req_type == npcm_pkg::REQ_PIXEL);
        base       = stage_in.item.first_pixel ? '0 : total_reg;
        sum        = {1'b0, base} + (npcm_pkg::TOTAL_W+1)'(stage_in.best.err);
        total_next = total_reg;
        if (valid_next)
        begin
            if (!stage_in.best.have)
            begin
                total_next = base;
            end
            else if (sum[npcm_pkg::TOTAL_W])
            begin
                total_next = '1;
            end
            else
            begin
                total_next = sum[npcm_pkg::TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            total_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            best_reg <= stage_in.best;
        end
    end

    assign out_valid = valid_reg;
    assign out_best  = best_reg;
    assign out_total = total_reg;

endmodule

/* design/nearest_palette_color_match_top.sv */
// top level: a row of palette cells that every transaction walks through
//
//  channel | dir | handshake          | tdata / tuser
//  s_      | in  | s_tvalid/s_tready  | load or pixel item, tuser = request kind
//  m_      | out | m_tvalid/m_tready  | match result, tuser = found
//
// one transaction enters per cycle unless the output stalls; each walks the cell row,
// two registers per cell, then its result is held in the output register.
// loads travel the same row and write their cell on the way, so order is kept.
// reset clears the usable marks, the running total and all valid bits at once.
// a stalled output freezes the whole row; s_tready is low only while a result waits.
module nearest_palette_color_match_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index[5:0], entry_is_unit[6], color_r[14:7], color_g[22:15],
    // color_b[30:23], first_pixel[31]
    input  logic [npcm_pkg::S_DATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // match_index[5:0], match_r[13:6], match_g[21:14], match_b[29:22],
    // match_error[47:30], err_total[87:48]
    output logic [npcm_pkg::M_DATA_W-1:0] m_tdata,
    // found[0]
    output logic                          m_tuser
);

    npcm_pkg::stage_t              chain [0:npcm_pkg::PALETTE_DEPTH];
    logic                          advance;
    npcm_pkg::best_t               res_best;
    logic [npcm_pkg::TOTAL_W-1:0]  res_total;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_comb
    begin
        chain[0]                    = '0;
        chain[0].valid              = s_tvalid;
        chain[0].item.req_type      = npcm_pkg::req_t'(s_tuser);
        chain[0].item.entry_index   = s_tdata[5:0];
        chain[0].item.entry_is_unit = s_tdata[6];
        chain[0].item.color_r       = s_tdata[14:7];
        chain[0].item.color_g       = s_tdata[22:15];
        chain[0].item.color_b       = s_tdata[30:23];
        chain[0].item.first_pixel   = s_tdata[31];
    end

    for (genvar i = 0; i < npcm_pkg::PALETTE_DEPTH; i++)
    begin : g_cell
        npcm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cell_id   (npcm_pkg::IDX_W'(i)),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    npcm_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .stage_in  (chain[npcm_pkg::PALETTE_DEPTH]),
        .out_valid (m_tvalid),
        .out_best  (res_best),
        .out_total (res_total)
    );

    assign m_tuser = res_best.have;
    assign m_tdata = {res_total, res_best.err, res_best.b, res_best.g, res_best.r, res_best.idx};

endmodule

/* design/npcm_checker.sv */
// port-level checks for the nearest palette color match top level
module npcm_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [npcm_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[47:0] == 48'd0)
        else $error("no-match result carries a color or error");

    a_errmax: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[47:30] <= 18'd195075)
        else $error("match error out of range");

endmodule

bind nearest_palette_color_match_top npcm_checker u_npcm_checker (.*);

/* sim/nearest_palette_color_match_top_test.sv */
// self-checking testbench for the nearest palette color match block
module nearest_palette_color_match_top_test;

    typedef struct packed
    {
        logic                          found;
        logic [npcm_pkg::IDX_W-1:0]    index;
        logic [npcm_pkg::CHAN_W-1:0]   r;
        logic [npcm_pkg::CHAN_W-1:0]   g;
        logic [npcm_pkg::CHAN_W-1:0]   b;
        logic [npcm_pkg::ERR_W-1:0]    err;
        logic [npcm_pkg::TOTAL_W-1:0]  total;
    } match_result_t;

    typedef struct
    {
        npcm_pkg::item_t item;
        bit              wait_drain;
    } request_t;

    localparam int SETTLE_CYCLES = 2 * npcm_pkg::PALETTE_DEPTH + 16;
    localparam int HOLD_CYCLES   = 400;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [npcm_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [npcm_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;

    // predictor state
    logic [npcm_pkg::CHAN_W-1:0]  pal_r [npcm_pkg::PALETTE_DEPTH];
    logic [npcm_pkg::CHAN_W-1:0]  pal_g [npcm_pkg::PALETTE_DEPTH];
    logic [npcm_pkg::CHAN_W-1:0]  pal_b [npcm_pkg::PALETTE_DEPTH];
    bit                           pal_usable [npcm_pkg::PALETTE_DEPTH];
    logic [npcm_pkg::TOTAL_W-1:0] error_total = '0;

    request_t      request_q[$];
    match_result_t pending_matches[$];
    request_t      cur_req;
    bit            offering   = 1'b0;
    bit            s_taken    = 1'b0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    bit            rx_hold    = 1'b0;
    bit            hold_start = 1'b0;
    int            fail_count = 0;
    match_result_t want;

    nearest_palette_color_match_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    function automatic int chan_dist_sq(input logic [npcm_pkg::CHAN_W-1:0] a,
                                        input logic [npcm_pkg::CHAN_W-1:0] c);
        int d;
        d = int'(a) - int'(c);
        return d * d;
    endfunction

    // loads update the palette copy, pixels search it and queue the expected match
    task automatic predict_palette_match(input npcm_pkg::item_t it);
        match_result_t res;
        bit            have;
        int            min_err;
        int            e;
        logic [npcm_pkg::TOTAL_W:0] sum;
        if (it.req_type == npcm_pkg::REQ_LOAD)
        begin
            pal_r[it.entry_index]      = it.color_r;
            pal_g[it.entry_index]      = it.color_g;
            pal_b[it.entry_index]      = it.color_b;
            pal_usable[it.entry_index] = it.entry_is_unit;
        end
        else
        begin
            res     = '0;
            have    = 1'b0;
            min_err = 0;
            if (it.first_pixel)
                error_total = '0;
            for (int j = 0; j < npcm_pkg::PALETTE_DEPTH; j++)
            begin
                if (pal_usable[j])
                begin
                    e = chan_dist_sq(pal_r[j], it.color_r) + chan_dist_sq(pal_g[j], it.color_g)
                        + chan_dist_sq(pal_b[j], it.color_b);
                    // strict compare keeps the lowest index on a tie
                    if (!have || e < min_err)
                    begin
                        have      = 1'b1;
                        min_err   = e;
                        res.index = npcm_pkg::IDX_W'(j);
                        res.r     = pal_r[j];
                        res.g     = pal_g[j];
                        res.b     = pal_b[j];
                    end
                end
            end
            if (have)
            begin
                sum         = {1'b0, error_total} + (npcm_pkg::TOTAL_W + 1)'(min_err);
                error_total = sum[npcm_pkg::TOTAL_W] ? '1 : sum[npcm_pkg::TOTAL_W-1:0];
                res.err     = npcm_pkg::ERR_W'(min_err);
            end
            res.found = have;
            res.total = error_total;
            pending_matches.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [npcm_pkg::TOTAL_W-1:0] exp_val,
                               input logic [npcm_pkg::TOTAL_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    task automatic push_item(input npcm_pkg::req_t kind, input int idx, input bit unit,
                             input int r, input int g, input int b, input bit first,
                             input bit drain);
        request_t rq;
        rq.item.req_type      = kind;
        rq.item.entry_index   = npcm_pkg::IDX_W'(idx);
        rq.item.entry_is_unit = unit;
        rq.item.color_r       = npcm_pkg::CHAN_W'(r);
        rq.item.color_g       = npcm_pkg::CHAN_W'(g);
        rq.item.color_b       = npcm_pkg::CHAN_W'(b);
        rq.item.first_pixel   = first;
        rq.wait_drain         = drain;
        request_q.push_back(rq);
    endtask

    // extremes and a few mid levels often, so exact ties come up
    function automatic int rand_chan();
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
            return (sel == 0) ? 0 : 255;
        else if (sel < 4)
            return 64 * $urandom_range(1, 3);
        return $urandom_range(255);
    endfunction

    task automatic queue_random_items(input int count, input bit with_wipe);
        int wipe_at;
        wipe_at = $urandom_range(count / 4, count / 2);
        for (int i = 0; i < count; i++)
        begin
            if (with_wipe && i == wipe_at)
            begin
                // clear every usable mark, match against an empty palette, then refill sixteen random slots
                for (int j = 0; j < npcm_pkg::PALETTE_DEPTH; j++)
                    push_item(npcm_pkg::REQ_LOAD, j, 1'b0, rand_chan(), rand_chan(),
                              rand_chan(), 1'($urandom_range(1)), 1'b0);
                for (int j = 0; j < 5; j++)
                    push_item(npcm_pkg::REQ_PIXEL, $urandom_range(63), 1'($urandom_range(1)),
                              rand_chan(), rand_chan(), rand_chan(), 1'($urandom_range(1)),
                              1'b0);
                for (int j = 0; j < 16; j++)
                    push_item(npcm_pkg::REQ_LOAD, $urandom_range(63), 1'b1, rand_chan(),
                              rand_chan(), rand_chan(), 1'($urandom_range(1)), 1'b0);
            end
            if ($urandom_range(3) == 0)
                push_item(npcm_pkg::REQ_LOAD, $urandom_range(63), $urandom_range(4) != 0,
                          rand_chan(), rand_chan(), rand_chan(), 1'($urandom_range(1)),
                          $urandom_range(99) == 0);
            else
                push_item(npcm_pkg::REQ_PIXEL, $urandom_range(63), 1'($urandom_range(1)),
                          rand_chan(), rand_chan(), rand_chan(), $urandom_range(19) == 0,
                          $urandom_range(99) == 0);
        end
    endtask

    task automatic wait_queue_empty();
        while (request_q.size() != 0 || offering)
            @(posedge clk);
    endtask

    // sender: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_taken)
            begin
                offering = 1'b0;
                s_taken  = 1'b0;
            end
            if (!offering)
            begin
                if (request_q.size() != 0
                    && (!request_q[0].wait_drain || pending_matches.size() == 0)
                    && $urandom_range(99) >= tx_idle_pct)
                begin
                    cur_req  = request_q.pop_front();
                    offering = 1'b1;
                    s_tdata  <= {cur_req.item.first_pixel, cur_req.item.color_b,
                                 cur_req.item.color_g, cur_req.item.color_r,
                                 cur_req.item.entry_is_unit, cur_req.item.entry_index};
                    s_tuser  <= cur_req.item.req_type;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_palette_match(cur_req.item);
            s_taken = 1'b1;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0h found %b",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                check_field("found", npcm_pkg::TOTAL_W'(want.found),
                            npcm_pkg::TOTAL_W'(m_tuser));
                check_field("match_index", npcm_pkg::TOTAL_W'(want.index),
                            npcm_pkg::TOTAL_W'(m_tdata[5:0]));
                check_field("match_r", npcm_pkg::TOTAL_W'(want.r),
                            npcm_pkg::TOTAL_W'(m_tdata[13:6]));
                check_field("match_g", npcm_pkg::TOTAL_W'(want.g),
                            npcm_pkg::TOTAL_W'(m_tdata[21:14]));
                check_field("match_b", npcm_pkg::TOTAL_W'(want.b),
                            npcm_pkg::TOTAL_W'(m_tdata[29:22]));
                check_field("match_error", npcm_pkg::TOTAL_W'(want.err),
                            npcm_pkg::TOTAL_W'(m_tdata[47:30]));
                check_field("err_total", want.total, m_tdata[87:48]);
            end
        end
    end

    // long receiver hold-off so the row fills and the input stalls
    initial
    begin
        while (!hold_start)
            @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        for (int j = 0; j < npcm_pkg::PALETTE_DEPTH; j++)
            pal_usable[j] = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 85;

        // empty palette, then a load that is not usable
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 0, 0, 0, 1'b1, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 63, 1'b1, 255, 255, 255, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_LOAD, 5, 1'b0, 10, 20, 30, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 5, 1'b0, 10, 20, 30, 1'b0, 1'b0);
        // first_pixel on a load is ignored
        push_item(npcm_pkg::REQ_LOAD, 63, 1'b1, 255, 255, 255, 1'b1, 1'b0);
        push_item(npcm_pkg::REQ_LOAD, 0, 1'b1, 0, 0, 0, 1'b0, 1'b0);
        // same color at a higher slot: tie goes to slot 0
        push_item(npcm_pkg::REQ_LOAD, 40, 1'b1, 0, 0, 0, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 0, 0, 0, 1'b1, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 255, 255, 255, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 255, 0, 0, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 128, 128, 128, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 0, 255, 255, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_LOAD, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        // largest single error
        push_item(npcm_pkg::REQ_LOAD, 63, 1'b0, 255, 255, 255, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 255, 255, 255, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 255, 255, 0, 1'b1, 1'b0);
        push_item(npcm_pkg::REQ_LOAD, 5, 1'b1, 10, 20, 30, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_LOAD, 63, 1'b1, 255, 0, 255, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 12, 18, 33, 1'b0, 1'b0);
        push_item(npcm_pkg::REQ_PIXEL, 0, 1'b0, 250, 3, 250, 1'b0, 1'b1);
        queue_random_items(260, 1'b0);
        wait_queue_empty();

        tx_idle_pct = 85;
        rx_idle_pct = 6;
        queue_random_items(220, 1'b1);
        wait_queue_empty();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_start  = 1'b1;
        queue_random_items(260, 1'b0);
        wait_queue_empty();

        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_matches.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_matches.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
